/* sv/ham6_pixel_encoder_defines.svh */
`ifndef HAM6_PIXEL_ENCODER_DEFINES_SVH
`define HAM6_PIXEL_ENCODER_DEFINES_SVH

// same-cycle implication
`define HAM6_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HAM6_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/ham6_pkg.sv */
package ham6_pkg;

  localparam int PALETTE_DEPTH = 16;

  localparam logic [2:0] W_RED   = 3'd3;
  localparam logic [2:0] W_GREEN = 3'd4;
  localparam logic [2:0] W_BLUE  = 3'd2;

  localparam logic [12:0] ERR_MAX = 13'd6525;

  localparam logic [1:0] MODE_PALETTE = 2'd0;
  localparam logic [1:0] MODE_BLUE    = 2'd1;
  localparam logic [1:0] MODE_RED     = 2'd2;
  localparam logic [1:0] MODE_GREEN   = 2'd3;

  localparam logic [2:0] REG_PAL_0_3   = 3'd0;
  localparam logic [2:0] REG_PAL_4_7   = 3'd1;
  localparam logic [2:0] REG_PAL_8_11  = 3'd2;
  localparam logic [2:0] REG_PAL_12_15 = 3'd3;
  localparam logic [2:0] REG_PAL_SIZE  = 3'd4;

  localparam logic [4:0] STEP_RED   = 5'd0;
  localparam logic [4:0] STEP_GREEN = 5'd1;
  localparam logic [4:0] STEP_BLUE  = 5'd2;
  localparam logic [4:0] STEP_PAL0  = 5'd3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  function automatic logic [11:0] chan_dist(logic [3:0] a, logic [3:0] b, logic [2:0] w);
    logic [3:0] d;
    logic [5:0] dw;
    d  = (a > b) ? (a - b) : (b - a);
    dw = 6'({2'b0, d} * {3'b0, w});
    return 12'({6'b0, dw} * {6'b0, dw});
  endfunction

  function automatic logic [12:0] color_dist(logic [11:0] a, logic [11:0] b);
    logic [12:0] sum;
    sum = {1'b0, chan_dist(a[11:8], b[11:8], W_RED)}
        + {1'b0, chan_dist(a[7:4], b[7:4], W_GREEN)}
        + {1'b0, chan_dist(a[3:0], b[3:0], W_BLUE)};
    return sum;
  endfunction

endpackage

/* sv/ham6_pixel_encoder.sv */
// Items are taken one at a time: src_stall stays high from accept until the result is
// issued. One candidate per cycle goes through the shared weighted-distance unit: three
// modify candidates, then N palette entries, N = min(palette_size, 16).
// Reset (synchronous): control idle, previous color and palette cleared,
// palette_size set to 16.
`include "ham6_pixel_encoder_defines.svh"

module ham6_pixel_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [11:0] source_pixel,
  input  logic        line_start,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [5:0]  ham_code,
  output logic [11:0] shown_color,
  output logic [12:0] pixel_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  ham6_pkg::state_t state;

  logic [11:0] palette [ham6_pkg::PALETTE_DEPTH];
  logic [4:0]  palette_size;
  logic [11:0] previous_color;
  logic [11:0] src;
  logic [4:0]  step;
  logic [12:0] best_err;
  logic [5:0]  best_code;
  logic [11:0] best_color;

  logic [2:0]  reg_idx;
  logic        cfg_write;
  logic [4:0]  count;
  logic [4:0]  last_step;
  logic [3:0]  pal_idx;
  logic [11:0] cand_color;
  logic [5:0]  cand_code;
  logic [12:0] cand_err;
  logic        take;
  logic        slot_free;
  logic        accept;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[5:3];
  assign cfg_write = psel && penable && pwrite;
  assign src_stall = (state != ham6_pkg::ST_IDLE);
  assign accept    = src_valid && !src_stall;
  assign slot_free = !res_valid || !res_stall;

  assign count     = (palette_size > 5'(ham6_pkg::PALETTE_DEPTH)) ?
                     5'(ham6_pkg::PALETTE_DEPTH) : palette_size;
  assign last_step = 5'(ham6_pkg::STEP_BLUE + count);
  assign pal_idx   = 4'(step - ham6_pkg::STEP_PAL0);

  always_comb begin
    case (step)
      ham6_pkg::STEP_RED: begin
        cand_color = {src[11:8], previous_color[7:0]};
        cand_code  = {ham6_pkg::MODE_RED, src[11:8]};
      end
      ham6_pkg::STEP_GREEN: begin
        cand_color = {previous_color[11:8], src[7:4], previous_color[3:0]};
        cand_code  = {ham6_pkg::MODE_GREEN, src[7:4]};
      end
      ham6_pkg::STEP_BLUE: begin
        cand_color = {previous_color[11:4], src[3:0]};
        cand_code  = {ham6_pkg::MODE_BLUE, src[3:0]};
      end
      default: begin
        cand_color = palette[pal_idx];
        cand_code  = {ham6_pkg::MODE_PALETTE, pal_idx};
      end
    endcase
  end

  assign cand_err = ham6_pkg::color_dist(src, cand_color);
  assign take     = (step == ham6_pkg::STEP_RED) || (cand_err < best_err);

  always_comb begin
    case (reg_idx)
      ham6_pkg::REG_PAL_0_3:   prdata = {16'b0, palette[3], palette[2], palette[1], palette[0]};
      ham6_pkg::REG_PAL_4_7:   prdata = {16'b0, palette[7], palette[6], palette[5], palette[4]};
      ham6_pkg::REG_PAL_8_11:  prdata = {16'b0, palette[11], palette[10], palette[9], palette[8]};
      ham6_pkg::REG_PAL_12_15: prdata = {16'b0, palette[15], palette[14], palette[13],
                                         palette[12]};
      ham6_pkg::REG_PAL_SIZE:  prdata = {59'b0, palette_size};
      default:                 prdata = 64'b0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ham6_pkg::PALETTE_DEPTH; i++) begin
        palette[i] <= 12'b0;
      end
      palette_size <= 5'd16;
    end else if (cfg_write) begin
      if (reg_idx == ham6_pkg::REG_PAL_SIZE) begin
        palette_size <= pwdata[4:0];
      end else if (reg_idx[2] == 1'b0) begin
        for (int i = 0; i < 4; i++) begin
          palette[{reg_idx[1:0], 2'(i)}] <= pwdata[12*i +: 12];
        end
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ham6_pkg::ST_IDLE;
      res_valid      <= 1'b0;
      previous_color <= 12'b0;
      step           <= 5'b0;
    end else begin
      if (res_valid && !res_stall && (state != ham6_pkg::ST_WAIT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ham6_pkg::ST_IDLE: begin
          if (accept) begin
            src   <= source_pixel;
            step  <= ham6_pkg::STEP_RED;
            state <= ham6_pkg::ST_RUN;
            if (line_start) begin
              previous_color <= palette[0];
            end
          end
        end
        ham6_pkg::ST_RUN: begin
          if (take) begin
            best_err   <= cand_err;
            best_code  <= cand_code;
            best_color <= cand_color;
          end
          if (step == last_step) begin
            state <= ham6_pkg::ST_WAIT;
          end else begin
            step <= step + 5'd1;
          end
        end
        ham6_pkg::ST_WAIT: begin
          if (slot_free) begin
            res_valid      <= 1'b1;
            ham_code       <= best_code;
            shown_color    <= best_color;
            pixel_error    <= best_err;
            previous_color <= best_color;
            state          <= ham6_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= ham6_pkg::ST_IDLE;
        end
      endcase
    end
  end

  `HAM6_ASSERT_NEXT(a_accept_starts, accept, (state == ham6_pkg::ST_RUN) && (step == ham6_pkg::STEP_RED), "accept did not start the candidate scan")
  `HAM6_ASSERT_NOW(a_step_bound, state == ham6_pkg::ST_RUN, step <= last_step, "candidate step past the last palette entry")
  `HAM6_ASSERT_NOW(a_err_range, res_valid, pixel_error <= ham6_pkg::ERR_MAX, "pixel error out of range")
  `HAM6_ASSERT_NEXT(a_prev_follows, (state == ham6_pkg::ST_WAIT) && slot_free, res_valid && (previous_color == shown_color), "previous color not updated with result")

endmodule
